FILE: design/cckb_pkg.sv
// shared types, constants and helpers for the color-keyed sprite blitter
package cckb_pkg;

    // largest image side the counters support
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);

    // field widths
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 24;
    localparam int POS_W   = DIM_W + 1;
    localparam int PROD_W  = 2 * DIM_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_PITCH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd7;

    // reset values
    localparam logic [DIM_W-1:0] RST_DEST_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_DEST_HEIGHT  = 13'd480;
    localparam logic [DIM_W-1:0] RST_DEST_PITCH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd1;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd1;
    localparam logic [DIM_W-1:0] RST_POS          = 13'd0;
    localparam logic [PIX_W-1:0] RST_KEY_COLOR    = 32'h0000_0000;

    typedef struct packed {
        logic [DIM_W-1:0]        dest_width;
        logic [DIM_W-1:0]        dest_height;
        logic [DIM_W-1:0]        dest_pitch;
        logic [DIM_W-1:0]        image_width;
        logic [DIM_W-1:0]        image_height;
        logic signed [DIM_W-1:0] pos_x;
        logic signed [DIM_W-1:0] pos_y;
        logic [PIX_W-1:0]        key_color;
    } t_cfg;

    // one pixel after position lookup, before clipping
    typedef struct packed {
        logic [PIX_W-1:0]        pixel;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic                    last;
    } t_scan;

    // last column or row index for a size register: zero counts as one,
    // anything above the maximum is clamped
    function automatic logic [CNT_W-1:0] last_index(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        begin
            if (v == '0) begin
                d = DIM_W'(1);
            end else if (v > DIM_W'(MAX_DIM)) begin
                d = DIM_W'(MAX_DIM);
            end else begin
                d = v;
            end
            last_index = CNT_W'(d - DIM_W'(1));
        end
    endfunction

endpackage

FILE: design/cckb_regs.sv
// configuration register file
module cckb_regs
    import cckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEST_WIDTH:   n_cfg.dest_width   = i_cfg_data[DIM_W-1:0];
                REG_DEST_HEIGHT:  n_cfg.dest_height  = i_cfg_data[DIM_W-1:0];
                REG_DEST_PITCH:   n_cfg.dest_pitch   = i_cfg_data[DIM_W-1:0];
                REG_IMAGE_WIDTH:  n_cfg.image_width  = i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = i_cfg_data[DIM_W-1:0];
                REG_POS_X:        n_cfg.pos_x        = i_cfg_data[DIM_W-1:0];
                REG_POS_Y:        n_cfg.pos_y        = i_cfg_data[DIM_W-1:0];
                REG_KEY_COLOR:    n_cfg.key_color    = i_cfg_data[PIX_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_width   <= RST_DEST_WIDTH;
            r_cfg.dest_height  <= RST_DEST_HEIGHT;
            r_cfg.dest_pitch   <= RST_DEST_PITCH;
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.pos_x        <= RST_POS;
            r_cfg.pos_y        <= RST_POS;
            r_cfg.key_color    <= RST_KEY_COLOR;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: design/cckb_scan.sv
// raster counters and input register: source position to destination position
module cckb_scan
    import cckb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [PIX_W-1:0] i_source_pixel,
    input  logic             i_adv,
    output logic             o_s1_valid,
    output t_scan            o_s1
);

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic             r_valid;
    t_scan            r_s1;
    t_scan            n_s1;
    logic             s1_free;
    logic             accept;
    logic [CNT_W-1:0] col_last;
    logic [CNT_W-1:0] row_last;
    logic             end_col;
    logic             end_row;

    assign s1_free    = !r_valid || i_adv;
    assign accept     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;
    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;

    assign col_last = last_index(i_cfg.image_width);
    assign row_last = last_index(i_cfg.image_height);
    // a counter past a shrunken size counts as being on the last index
    assign end_col  = r_col >= col_last;
    assign end_row  = r_row >= row_last;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (end_col) begin
                n_col = '0;
                n_row = end_row ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
        n_s1.pixel = i_source_pixel;
        n_s1.dx    = POS_W'(i_cfg.pos_x) + $signed({{(POS_W-CNT_W){1'b0}}, r_col});
        n_s1.dy    = POS_W'(i_cfg.pos_y) + $signed({{(POS_W-CNT_W){1'b0}}, r_row});
        n_s1.last  = end_col && end_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (s1_free) begin
                r_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    // the image's last pixel rewinds the raster counters
    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && end_col && end_row) |=> (r_col == '0 && r_row == '0))
        else $error("counters not rewound after last pixel");

endmodule

FILE: design/cckb_result.sv
// clipping, color key test, address multiply-add and result register
module cckb_result
    import cckb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_s1_valid,
    input  t_scan             i_s1,
    output logic              o_adv,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_write_enable,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic [PIX_W-1:0]  o_pixel_value,
    output logic              o_last_pixel
);

    logic              r_valid;
    logic              r_we;
    logic [ADDR_W-1:0] r_addr;
    logic [PIX_W-1:0]  r_value;
    logic              r_last;

    logic [DIM_W-1:0]  dx_u;
    logic [DIM_W-1:0]  dy_u;
    logic              on_dest;
    logic              n_we;
    logic [PROD_W-1:0] prod;
    logic [ADDR_W-1:0] n_addr;

    assign o_adv = !r_valid || !i_out_stall;

    assign dx_u    = i_s1.dx[DIM_W-1:0];
    assign dy_u    = i_s1.dy[DIM_W-1:0];
    assign on_dest = !i_s1.dx[POS_W-1] && !i_s1.dy[POS_W-1] &&
                     (dx_u < i_cfg.dest_width) && (dy_u < i_cfg.dest_height);
    assign n_we    = on_dest && (i_s1.pixel != i_cfg.key_color);
    assign prod    = PROD_W'(dy_u) * PROD_W'(i_cfg.dest_pitch);
    assign n_addr  = prod[ADDR_W-1:0] + ADDR_W'(dx_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_s1_valid;
        end
    end

    // skipped pixels carry zero address and value
    always_ff @(posedge i_clk) begin
        if (o_adv && i_s1_valid) begin
            r_we    <= n_we;
            r_addr  <= n_we ? n_addr : '0;
            r_value <= n_we ? i_s1.pixel : '0;
            r_last  <= i_s1.last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_write_enable  = r_we;
    assign o_pixel_address = r_addr;
    assign o_pixel_value   = r_value;
    assign o_last_pixel    = r_last;

    a_skip_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_we) |-> (r_addr == '0 && r_value == '0))
        else $error("skipped pixel carries nonzero payload");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> r_valid)
        else $error("stalled result dropped");

endmodule

FILE: design/clipped_color_key_blit.sv
// top level of the color-keyed sprite blitter with destination clipping
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------------------
//  pixel in | in        | i_in_valid / o_in_stall    | i_source_pixel
//  result   | out       | o_out_valid / i_out_stall  | o_write_enable, o_pixel_address,
//           |           |                            | o_pixel_value, o_last_pixel
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one pixel transfer per clock while the output does not stall
// stage one turns the raster counters into a signed destination position, stage two clips,
// tests the key color and forms row * pitch + column with one 13x13 multiply and an add
// synchronous active-low reset clears the counters, the stage valids and the config registers
// a stalled result holds; input stalls only when both stages are full and the output stalls
// configuration always ready; user must write it only while no pixel is in flight, unchecked
module clipped_color_key_blit
    import cckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_source_pixel,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_write_enable,
    output logic [ADDR_W-1:0]     o_pixel_address,
    output logic [PIX_W-1:0]      o_pixel_value,
    output logic                  o_last_pixel,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;        // live register values
    t_scan s1;         // stage one payload
    logic  s1_valid;
    logic  adv;        // result register can take a new pixel

    cckb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // raster position tracking, registered pixel and destination position
    cckb_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_source_pixel (i_source_pixel),
        .i_adv          (adv),
        .o_s1_valid     (s1_valid),
        .o_s1           (s1)
    );

    // clip, key and address, then the result register
    cckb_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_s1_valid      (s1_valid),
        .i_s1            (s1),
        .o_adv           (adv),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last_pixel    (o_last_pixel)
    );

    // backpressure reaches the input only when the whole pipe is blocked
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall && s1_valid))
        else $error("input stalled while the pipe has room");

endmodule

FILE: tb/blit_result_checker.sv
// watches the blitter channels, predicts each destination write and compares
module blit_result_checker
    import cckb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [PIX_W-1:0]      i_source_pixel,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_write_enable,
    input  logic [ADDR_W-1:0]     i_pixel_address,
    input  logic [PIX_W-1:0]      i_pixel_value,
    input  logic                  i_last_pixel,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_error_count,
    output int                    o_pending
);

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] pixel_address;
        logic [PIX_W-1:0]  pixel_value;
        logic              last_pixel;
    } t_blit_write;

    t_blit_write      expected_writes[$];
    t_blit_write      want;
    t_cfg             blit_cfg;
    logic [CNT_W-1:0] col_cnt;
    logic [CNT_W-1:0] row_cnt;
    int               mismatch_count = 0;

    // zero counts as one, anything past the counter range is clamped
    function automatic int image_side(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic t_blit_write predict_write(input logic [PIX_W-1:0] pixel);
        t_blit_write r;
        int          dx;
        int          dy;
        int          lin;
        logic        on_dest;
        dx = int'($signed(blit_cfg.pos_x)) + int'(col_cnt);
        dy = int'($signed(blit_cfg.pos_y)) + int'(row_cnt);
        on_dest = dx >= 0 && dy >= 0 && dx < int'(blit_cfg.dest_width)
                  && dy < int'(blit_cfg.dest_height);
        lin = dy * int'(blit_cfg.dest_pitch) + dx;
        r.write_enable  = on_dest && pixel != blit_cfg.key_color;
        r.pixel_address = r.write_enable ? lin[ADDR_W-1:0] : '0;
        r.pixel_value   = r.write_enable ? pixel : '0;
        r.last_pixel    = int'(col_cnt) >= image_side(blit_cfg.image_width) - 1
                          && int'(row_cnt) >= image_side(blit_cfg.image_height) - 1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blit_cfg.dest_width   = RST_DEST_WIDTH;
            blit_cfg.dest_height  = RST_DEST_HEIGHT;
            blit_cfg.dest_pitch   = RST_DEST_PITCH;
            blit_cfg.image_width  = RST_IMAGE_WIDTH;
            blit_cfg.image_height = RST_IMAGE_HEIGHT;
            blit_cfg.pos_x        = RST_POS;
            blit_cfg.pos_y        = RST_POS;
            blit_cfg.key_color    = RST_KEY_COLOR;
            col_cnt = '0;
            row_cnt = '0;
            expected_writes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEST_WIDTH:   blit_cfg.dest_width   = i_cfg_data[DIM_W-1:0];
                    REG_DEST_HEIGHT:  blit_cfg.dest_height  = i_cfg_data[DIM_W-1:0];
                    REG_DEST_PITCH:   blit_cfg.dest_pitch   = i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_WIDTH:  blit_cfg.image_width  = i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: blit_cfg.image_height = i_cfg_data[DIM_W-1:0];
                    REG_POS_X:        blit_cfg.pos_x        = i_cfg_data[DIM_W-1:0];
                    REG_POS_Y:        blit_cfg.pos_y        = i_cfg_data[DIM_W-1:0];
                    REG_KEY_COLOR:    blit_cfg.key_color    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected result", '0, {31'd0, i_write_enable});
                end else begin
                    want = expected_writes.pop_front();
                    if (i_write_enable !== want.write_enable)
                        report_mismatch("write_enable", 32'(want.write_enable),
                                        32'(i_write_enable));
                    if (i_pixel_address !== want.pixel_address)
                        report_mismatch("pixel_address", 32'(want.pixel_address),
                                        32'(i_pixel_address));
                    if (i_pixel_value !== want.pixel_value)
                        report_mismatch("pixel_value", want.pixel_value, i_pixel_value);
                    if (i_last_pixel !== want.last_pixel)
                        report_mismatch("last_pixel", 32'(want.last_pixel),
                                        32'(i_last_pixel));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = predict_write(i_source_pixel);
                expected_writes.push_back(want);
                // raster walk: the end of row test uses the clamped sizes
                if (int'(col_cnt) >= image_side(blit_cfg.image_width) - 1) begin
                    col_cnt = '0;
                    if (int'(row_cnt) >= image_side(blit_cfg.image_height) - 1)
                        row_cnt = '0;
                    else
                        row_cnt = row_cnt + CNT_W'(1);
                end else begin
                    col_cnt = col_cnt + CNT_W'(1);
                end
            end
        end
        o_pending     <= expected_writes.size();
        o_error_count <= mismatch_count;
    end

endmodule

FILE: tb/tb_clipped_color_key_blit.sv
// top of the blitter testbench: clock, reset, pixel and register stimulus, verdict
module tb_clipped_color_key_blit
    import cckb_pkg::*;
;

    // receiver hold-off length for the back-pressure phase
    localparam int HOLD_CYCLES   = 200;
    // random pixel budget after the directed part
    localparam int RANDOM_PIXELS = 1850;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_source_pixel = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_write_enable;
    logic [ADDR_W-1:0]     o_pixel_address;
    logic [PIX_W-1:0]      o_pixel_value;
    logic                  o_last_pixel;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int error_count;
    int pending_writes;

    // idling knobs, percent per cycle, changed between phases
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    // one-shot request for a long receiver hold-off
    bit hold_pending       = 1'b0;

    clipped_color_key_blit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_source_pixel  (i_source_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_enable  (o_write_enable),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_last_pixel    (o_last_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    blit_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_source_pixel  (i_source_pixel),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_write_enable  (o_write_enable),
        .i_pixel_address (o_pixel_address),
        .i_pixel_value   (o_pixel_value),
        .i_last_pixel    (o_last_pixel),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_pending       (pending_writes)
    );

    // 10 unit period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, or a long counted hold-off when asked for
    initial begin
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
                @(posedge i_clk);
            end
        end
    end

    // one pixel transfer; random idle cycles ahead of it, payload held while stalled
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_source_pixel <= px;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // stop offering pixels and let the pipeline empty; the first edge makes the
    // last transfer visible in the pending count, the tail covers the two stages
    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // writes every register in index order; upper data bits above a 13-bit field
    // are random so the truncation is exercised too
    task automatic program_blit(input logic [DIM_W-1:0] dw, dh, pitch, iw, ih, px, py,
                                input logic [PIX_W-1:0] key);
        logic [CFG_DATA_W-1:0] regs[8];
        int                    k;
        regs[REG_DEST_WIDTH]   = {19'($urandom), dw};
        regs[REG_DEST_HEIGHT]  = {19'($urandom), dh};
        regs[REG_DEST_PITCH]   = {19'($urandom), pitch};
        regs[REG_IMAGE_WIDTH]  = {19'($urandom), iw};
        regs[REG_IMAGE_HEIGHT] = {19'($urandom), ih};
        regs[REG_POS_X]        = {19'($urandom), px};
        regs[REG_POS_Y]        = {19'($urandom), py};
        regs[REG_KEY_COLOR]    = key;
        for (k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(k);
            i_cfg_data  <= regs[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // destination sizes: mostly small so clipping is common, plus zero and the extremes
    function automatic logic [DIM_W-1:0] pick_dest_dim();
        int r;
        r = $urandom_range(99);
        if (r < 80) return DIM_W'($urandom_range(1, 24));
        if (r < 86) return '0;
        if (r < 92) return '1;
        if (r < 96) return DIM_W'(MAX_DIM);
        return DIM_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_pitch();
        int r;
        r = $urandom_range(99);
        if (r < 80) return DIM_W'($urandom_range(1, 30));
        if (r < 85) return '0;
        if (r < 93) return '1;
        return DIM_W'($urandom);
    endfunction

    // image sizes: small images mostly; zero and oversize get clamped by the block
    function automatic logic [DIM_W-1:0] pick_image_dim();
        int r;
        r = $urandom_range(99);
        if (r < 85) return DIM_W'($urandom_range(1, 8));
        if (r < 89) return '0;
        if (r < 93) return DIM_W'(MAX_DIM);
        if (r < 97) return '1;
        return DIM_W'(MAX_DIM + 1);
    endfunction

    // positions near the destination, plus the signed extremes
    function automatic logic [DIM_W-1:0] pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 80) return DIM_W'($urandom_range(0, 40) - 12);
        if (r < 86) return {1'b1, {(DIM_W-1){1'b0}}};
        if (r < 92) return {1'b0, {(DIM_W-1){1'b1}}};
        return DIM_W'($urandom);
    endfunction

    // pixel values: a good share hit the key color, the rest random or all 0s / all 1s
    function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] key);
        int r;
        r = $urandom_range(99);
        if (r < 20) return key;
        if (r < 25) return '0;
        if (r < 30) return '1;
        return $urandom;
    endfunction

    initial begin
        logic [DIM_W-1:0] dw, dh, pitch, iw, ih, px, py;
        logic [PIX_W-1:0] key;
        int               n;
        int               k;
        int               phase;
        int               pixels_sent;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: 1x1 image at the origin, key 0, so every pixel is last
        send_pixel('0);
        send_pixel('1);
        drain_pipeline();

        sender_idle_pct    = 7;
        receiver_stall_pct = 7;

        // 4x3 image hanging off the top-left corner of an 8x6 buffer, key inside it
        program_blit(13'd8, 13'd6, 13'd10, 13'd4, 13'd3, 13'h1FFE, 13'h1FFF,
                     32'hDEAD_BEEF);
        for (k = 0; k < 12; k++) begin
            if (k == 6)
                send_pixel(32'hDEAD_BEEF);
            else if (k == 0)
                send_pixel('0);
            else if (k == 11)
                send_pixel('1);
            else
                send_pixel($urandom);
        end
        drain_pipeline();

        // largest buffer and far corner: row * pitch + column wraps past 24 bits
        program_blit('1, '1, '1, 13'd2, 13'd1, 13'h0FFF, 13'h0FFF, 32'h1234_5678);
        send_pixel($urandom);
        send_pixel($urandom);
        drain_pipeline();

        // empty destination: nothing can be written
        program_blit('0, '0, 13'd640, 13'd1, 13'd1, '0, '0, '0);
        send_pixel($urandom);
        send_pixel($urandom);
        drain_pipeline();

        // zero width taken as one, oversize height clamped: the row counter climbs
        program_blit(13'd640, 13'd480, 13'd640, '0, '1, '0, '0, '0);
        send_pixel($urandom);
        send_pixel($urandom);
        drain_pipeline();

        // image shrinks under a row counter that is already past its last row
        program_blit(13'd640, 13'd480, 13'd640, 13'd3, 13'd1, 13'd5, 13'd5, '1);
        send_pixel($urandom);
        send_pixel('1);
        drain_pipeline();

        // random phases; the idling mode rotates through its four settings from phase to phase
        phase       = 0;
        pixels_sent = 0;
        while (pixels_sent < RANDOM_PIXELS) begin
            case (phase % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 54;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 54;
                end
                default: begin
                    sender_idle_pct    = 7;
                    receiver_stall_pct = 7;
                end
            endcase

            dw    = pick_dest_dim();
            dh    = pick_dest_dim();
            pitch = pick_pitch();
            iw    = pick_image_dim();
            ih    = pick_image_dim();
            px    = pick_pos();
            py    = pick_pos();
            case ($urandom_range(3))
                0: key = '0;
                1: key = '1;
                default: key = $urandom;
            endcase
            program_blit(dw, dh, pitch, iw, ih, px, py, key);

            // whole images when the size is small; some phases stop mid-image
            if (iw >= 1 && iw <= 8 && ih >= 1 && ih <= 8)
                n = int'(iw) * int'(ih) * $urandom_range(1, 6);
            else
                n = $urandom_range(20, 80);
            if ($urandom_range(99) < 25)
                n = n + $urandom_range(1, 5);

            // back-pressure: receiver holds off while the sender keeps offering,
            // so both stages fill and the input stalls
            if (phase == 6) begin
                sender_idle_pct = 0;
                hold_pending    = 1'b1;
                if (n < 60)
                    n = 60;
            end

            for (k = 0; k < n; k++)
                send_pixel(pick_pixel(key));
            pixels_sent = pixels_sent + n;
            drain_pipeline();
            phase++;
        end

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
